// File: src/ccfd_pkg.sv
// Shared types, constants and the CRC step function of the COBS/CRC-16 frame decoder.
package ccfd_pkg;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_MSB         = 16'h8000;
    localparam logic [15:0] TAIL_LEN        = 16'd2;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd256;
    localparam logic [7:0]  CODE_START      = 8'h00;
    localparam logic [7:0]  CODE_FULL_RUN   = 8'hFF;
    localparam logic [7:0]  DELIMITER       = 8'h00;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic {
        OP_BYTE,
        OP_END
    } op_kind_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_TOO_SHORT = 3'd1,
        ERR_EMPTY     = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_CRC       = 3'd4
    } err_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  data;
        logic [15:0] index;
        err_t        err;
        logic [15:0] len;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_push_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_head_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((crc & CRC_MSB) != 16'h0000)
            begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// File: src/ccfd_rx_if.sv
// Handshake interface that carries received encoded bytes.
interface ccfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/ccfd_res_if.sv
// Handshake interface that carries decoded bytes and frame reports.
interface ccfd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [15:0] out_index;
    logic        byte_valid;
    logic        frame_end;
    logic        frame_good;
    logic [15:0] frame_len;
    logic [2:0]  error_code;

    modport source (output valid, output out_byte, output out_index, output byte_valid,
                    output frame_end, output frame_good, output frame_len,
                    output error_code, input ready);
    modport sink (input valid, input out_byte, input out_index, input byte_valid,
                  input frame_end, input frame_good, input frame_len,
                  input error_code, output ready);
endinterface

// File: src/ccfd_front.sv
// Front end: COBS run tracking, position and overflow, and classification into operations.
module ccfd_front (
    input  logic                clk,
    input  logic                rst_n,
    ccfd_rx_if.sink             rx,
    input  logic [15:0]         max_frame_len,
    input  logic                queue_ready,
    output ccfd_pkg::op_push_t  push
);

    logic [15:0] wp_reg;
    logic [15:0] wp_next;
    logic [7:0]  run_reg;
    logic [7:0]  run_next;
    logic [7:0]  last_code_reg;
    logic [7:0]  last_code_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic        accept;
    logic        full;

    assign rx.ready = queue_ready;
    assign accept   = rx.valid && queue_ready;
    assign full     = wp_reg >= max_frame_len;

    always_comb
    begin
        wp_next        = wp_reg;
        run_next       = run_reg;
        last_code_next = last_code_reg;
        ovf_next       = ovf_reg;
        push.valid     = 1'b0;
        push.op.kind   = ccfd_pkg::OP_BYTE;
        push.op.data   = rx.rx_byte;
        push.op.index  = wp_reg;
        push.op.err    = ccfd_pkg::ERR_OK;
        push.op.len    = wp_reg - ccfd_pkg::TAIL_LEN;
        if (accept)
        begin
            if (rx.rx_byte == ccfd_pkg::DELIMITER)
            begin
                if (wp_reg != 16'd0)
                begin
                    push.valid   = 1'b1;
                    push.op.kind = ccfd_pkg::OP_END;
                    push.op.data = 8'h00;
                    push.op.index = 16'd0;
                    if (ovf_reg)
                    begin
                        push.op.err = ccfd_pkg::ERR_OVERFLOW;
                    end
                    else if (wp_reg < ccfd_pkg::TAIL_LEN)
                    begin
                        push.op.err = ccfd_pkg::ERR_TOO_SHORT;
                    end
                    else if (wp_reg == ccfd_pkg::TAIL_LEN)
                    begin
                        push.op.err = ccfd_pkg::ERR_EMPTY;
                    end
                end
                wp_next        = 16'd0;
                run_next       = 8'd0;
                last_code_next = ccfd_pkg::CODE_START;
                ovf_next       = 1'b0;
            end
            else if (run_reg != 8'd0)
            begin
                run_next = run_reg - 8'd1;
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    push.valid = 1'b1;
                    wp_next    = wp_reg + 16'd1;
                end
            end
            else if (last_code_reg != ccfd_pkg::CODE_FULL_RUN &&
                     last_code_reg != ccfd_pkg::CODE_START)
            begin
                // The implied zero of the previous run; on overflow the code byte is refused.
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    push.valid     = 1'b1;
                    push.op.data   = 8'h00;
                    wp_next        = wp_reg + 16'd1;
                    last_code_next = rx.rx_byte;
                    run_next       = rx.rx_byte - 8'd1;
                end
            end
            else
            begin
                last_code_next = rx.rx_byte;
                run_next       = rx.rx_byte - 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= 16'd0;
            run_reg       <= 8'd0;
            last_code_reg <= ccfd_pkg::CODE_START;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            run_reg       <= run_next;
            last_code_reg <= last_code_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule

// File: src/ccfd_queue.sv
// Short operation queue that decouples the front end from the back end.
module ccfd_queue #(
    parameter int unsigned DEPTH = ccfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ccfd_pkg::op_push_t  push,
    output logic                push_ready,
    output ccfd_pkg::op_head_t  head,
    input  logic                pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ccfd_pkg::op_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign head.valid = count_reg != '0;
    assign head.op    = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/ccfd_back.sv
// Back end: running CRC behind the two-byte tail, frame verdict and the output register.
module ccfd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ccfd_pkg::op_head_t  head,
    output logic                pop,
    ccfd_res_if.source          res
);

    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      tail_reg;
    logic [15:0]      tail_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       byte_reg;
    logic [15:0]      index_reg;
    logic             byte_valid_reg;
    logic             frame_end_reg;
    logic             good_reg;
    logic [15:0]      len_reg;
    ccfd_pkg::err_t   err_reg;
    ccfd_pkg::err_t   err_calc;
    logic [15:0]      got_crc;

    assign pop     = head.valid && (!valid_reg || res.ready);
    assign got_crc = {tail_reg[7:0], tail_reg[15:8]};

    always_comb
    begin
        err_calc = head.op.err;
        if (head.op.err == ccfd_pkg::ERR_OK && crc_reg != got_crc)
        begin
            err_calc = ccfd_pkg::ERR_CRC;
        end
    end

    always_comb
    begin
        crc_next   = crc_reg;
        tail_next  = tail_reg;
        valid_next = valid_reg && !res.ready;
        if (pop)
        begin
            valid_next = 1'b1;
            if (head.op.kind == ccfd_pkg::OP_END)
            begin
                crc_next  = ccfd_pkg::CRC_INIT;
                tail_next = 16'h0000;
            end
            else
            begin
                if (head.op.index >= ccfd_pkg::TAIL_LEN)
                begin
                    crc_next = ccfd_pkg::crc_feed(crc_reg, tail_reg[15:8]);
                end
                tail_next = {tail_reg[7:0], head.op.data};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= ccfd_pkg::CRC_INIT;
            tail_reg  <= 16'h0000;
            valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head.op.kind == ccfd_pkg::OP_END)
            begin
                byte_reg       <= 8'h00;
                index_reg      <= 16'd0;
                byte_valid_reg <= 1'b0;
                frame_end_reg  <= 1'b1;
                good_reg       <= err_calc == ccfd_pkg::ERR_OK;
                len_reg        <= (err_calc == ccfd_pkg::ERR_OK) ? head.op.len : 16'd0;
                err_reg        <= err_calc;
            end
            else
            begin
                byte_reg       <= head.op.data;
                index_reg      <= head.op.index;
                byte_valid_reg <= 1'b1;
                frame_end_reg  <= 1'b0;
                good_reg       <= 1'b0;
                len_reg        <= 16'd0;
                err_reg        <= ccfd_pkg::ERR_OK;
            end
        end
    end

    assign res.valid      = valid_reg;
    assign res.out_byte   = byte_reg;
    assign res.out_index  = index_reg;
    assign res.byte_valid = byte_valid_reg;
    assign res.frame_end  = frame_end_reg;
    assign res.frame_good = good_reg;
    assign res.frame_len  = len_reg;
    assign res.error_code = err_reg;

endmodule

// File: src/cobs_crc16_frame_decoder_core.sv
// The COBS frame decoder with CRC-16/CCITT-FALSE check, top level.
// The decoder accepts one encoded byte per clock cycle while its queue has room and gives at most one result per
// byte: a decoded byte with its index, or a frame report at each nonempty delimiter. A
// result is written into the queue when its byte is transferred, moves into the output
// register when the back end pops it while the output register is free, and it is held
// there until it is taken. The rate is set by the combinational COBS state update in the
// front end and the combinational eight-bit CRC step in the back end; the queue between
// them lets input keep flowing for QUEUE_DEPTH items while the output is stalled.
module cobs_crc16_frame_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = ccfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ccfd_rx_if.sink     rx,
    ccfd_res_if.source  res,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]         max_len_reg;
    logic [15:0]         max_len_next;
    logic                queue_ready;
    logic                pop;
    ccfd_pkg::op_push_t  push;
    ccfd_pkg::op_head_t  head;

    assign max_len_next = cfg_we ? cfg_wdata : max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= ccfd_pkg::MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    ccfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx),
        .max_frame_len (max_len_reg),
        .queue_ready   (queue_ready),
        .push          (push)
    );

    ccfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (queue_ready),
        .head       (head),
        .pop        (pop)
    );

    ccfd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

// File: src/ccfd_checker.sv
// Port-level assertions for the frame decoder and the bind that attaches them.
module ccfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  out_byte,
    input logic [15:0] out_index,
    input logic        byte_valid,
    input logic        frame_end,
    input logic        frame_good,
    input logic [15:0] frame_len,
    input logic [2:0]  error_code
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(out_index)
        && $stable(byte_valid) && $stable(frame_end) && $stable(error_code))
    else $error("stalled result changed");

    // Every result is either a decoded byte or a frame report.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> byte_valid != frame_end)
    else $error("result is neither or both of byte and frame report");

    // A good frame carries no error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_good |-> frame_end && error_code == ccfd_pkg::ERR_OK)
    else $error("good frame with error code");

    // A decoded byte carries no frame verdict, and a bad frame has zero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (byte_valid || (frame_end && !frame_good)) |->
        frame_len == 16'd0 && !frame_good)
    else $error("frame length or verdict on a result that has none");

endmodule

bind cobs_crc16_frame_decoder_core ccfd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .out_byte   (res.out_byte),
    .out_index  (res.out_index),
    .byte_valid (res.byte_valid),
    .frame_end  (res.frame_end),
    .frame_good (res.frame_good),
    .frame_len  (res.frame_len),
    .error_code (res.error_code)
);

// File: verif/tb_cobs_crc16_frame_decoder_core.sv
// Self-checking testbench for the COBS frame decoder with CRC-16 check, directed and random streams.
module tb_cobs_crc16_frame_decoder_core;

    localparam logic [15:0] CCITT_POLY       = 16'h1021;
    localparam logic [15:0] CCITT_INIT       = 16'hFFFF;
    localparam int          MAX_WAIT         = 6;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          LONG_HOLD_CYCLES = 80;
    localparam int          QUIET_LIMIT      = 20000;
    localparam int          RUN_LIMIT        = 4000000;

    // Lone delimiter, a one-byte frame, a two-byte frame and a frame with a bad CRC.
    localparam int          OPENING_LEN = 13;
    localparam logic [8*OPENING_LEN-1:0] OPENING = {
        8'h00,
        8'h02, 8'hFF, 8'h00,
        8'h03, 8'h12, 8'h34, 8'h00,
        8'h04, 8'h01, 8'h02, 8'h03, 8'h00
    };

    // With a limit of two, this drops a data byte and then two implied zeros.
    localparam int          SPILL_LEN = 7;
    localparam logic [8*SPILL_LEN-1:0] SPILL = {
        8'h04, 8'h01, 8'h02, 8'h03, 8'h02, 8'h05, 8'h00
    };

    typedef struct packed {
        logic [7:0]      data;
        logic [15:0]     index;
        logic            byte_valid;
        logic            frame_end;
        logic            frame_good;
        logic [15:0]     len;
        ccfd_pkg::err_t  err;
    } decoder_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    ccfd_rx_if  rx_link();
    ccfd_res_if res_link();

    cobs_crc16_frame_decoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_link),
        .res       (res_link),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [7:0]      rx_stream[$];
    logic [7:0]      frame_body[$];
    logic [7:0]      frame_wire[$];
    decoder_result_t frame_results_due[$];

    logic [15:0] dec_limit;
    logic [15:0] dec_pos;
    logic [7:0]  dec_run;
    logic [7:0]  dec_code;
    logic        dec_ovf;
    logic [15:0] dec_crc;
    logic [15:0] dec_tail;

    int send_wait;
    int take_wait;
    bit send_steady;
    bit take_steady;
    bit hold_req;
    bit hold_out;

    int items_queued;
    int bytes_received;
    int bytes_checked;
    int frames_checked;
    int frames_good;
    int limit_writes;
    int mismatches;

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CCITT_POLY;
        end
        return r;
    endfunction

    function automatic void clear_decoder();
        dec_pos  = '0;
        dec_run  = '0;
        dec_code = ccfd_pkg::CODE_START;
        dec_ovf  = 1'b0;
        dec_crc  = CCITT_INIT;
        dec_tail = '0;
    endfunction

    function automatic bit store_decoded(input logic [7:0] b);
        decoder_result_t r;
        if (dec_pos >= dec_limit)
        begin
            dec_ovf = 1'b1;
            return 1'b0;
        end
        if (dec_pos >= ccfd_pkg::TAIL_LEN)
            dec_crc = crc16_step(dec_crc, dec_tail[15:8]);
        r = '0;
        r.data = b;
        r.index = dec_pos;
        r.byte_valid = 1'b1;
        frame_results_due.push_back(r);
        dec_tail = {dec_tail[7:0], b};
        dec_pos = dec_pos + 16'd1;
        return 1'b1;
    endfunction

    function automatic void cobs_decode_step(input logic [7:0] b);
        decoder_result_t r;
        logic [15:0]     crc_rx;
        r = '0;
        if (b == ccfd_pkg::DELIMITER)
        begin
            if (dec_pos != 16'd0)
            begin
                crc_rx = {dec_tail[7:0], dec_tail[15:8]};
                r.frame_end = 1'b1;
                if (dec_ovf)
                    r.err = ccfd_pkg::ERR_OVERFLOW;
                else if (dec_pos < ccfd_pkg::TAIL_LEN)
                    r.err = ccfd_pkg::ERR_TOO_SHORT;
                else if (dec_pos == ccfd_pkg::TAIL_LEN)
                    r.err = ccfd_pkg::ERR_EMPTY;
                else if (dec_crc != crc_rx)
                    r.err = ccfd_pkg::ERR_CRC;
                else
                begin
                    r.err = ccfd_pkg::ERR_OK;
                    r.frame_good = 1'b1;
                    r.len = dec_pos - ccfd_pkg::TAIL_LEN;
                end
                frame_results_due.push_back(r);
            end
            clear_decoder();
        end
        else if (dec_run != 8'd0)
        begin
            dec_run = dec_run - 8'd1;
            void'(store_decoded(b));
        end
        // A code byte is only taken once the implied zero of the previous run fits.
        else if (dec_code == ccfd_pkg::CODE_FULL_RUN || dec_code == ccfd_pkg::CODE_START
                 || store_decoded(8'h00))
        begin
            dec_code = b;
            dec_run = b - 8'd1;
        end
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        rx_stream.push_back(b);
        items_queued++;
    endtask

    task automatic fill_body(input int n, input int zero_odds);
        for (int k = 0; k < n; k++)
            frame_body.push_back(($urandom_range(1, zero_odds) == 1) ? 8'h00
                                                                     : 8'($urandom_range(1, 255)));
    endtask

    task automatic send_body(input bit with_crc, input bit tamper, input bit cut);
        logic [15:0] crc;
        int          ph;
        int          run;
        int          stop;
        crc = CCITT_INIT;
        if (with_crc)
        begin
            for (int k = 0; k < frame_body.size(); k++)
                crc = crc16_step(crc, frame_body[k]);
            frame_body.push_back(crc[7:0]);
            frame_body.push_back(crc[15:8]);
        end
        frame_wire.delete();
        frame_wire.push_back(8'h01);
        ph = 0;
        run = 1;
        for (int k = 0; k < frame_body.size(); k++)
        begin
            if (frame_body[k] != 8'h00)
            begin
                frame_wire.push_back(frame_body[k]);
                run++;
            end
            if (frame_body[k] == 8'h00 || run == 255)
            begin
                frame_wire[ph] = 8'(run);
                frame_wire.push_back(8'h01);
                ph = frame_wire.size() - 1;
                run = 1;
            end
        end
        frame_wire[ph] = 8'(run);
        if (tamper)
            frame_wire[$urandom_range(0, frame_wire.size() - 1)] = 8'($urandom_range(1, 255));
        stop = cut ? $urandom_range(1, frame_wire.size()) : frame_wire.size();
        for (int k = 0; k < stop; k++)
            queue_byte(frame_wire[k]);
        if (!cut)
            queue_byte(ccfd_pkg::DELIMITER);
        frame_body.delete();
    endtask

    task automatic random_frame();
        int kind;
        kind = $urandom_range(0, 99);
        frame_body.delete();
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 12))
                queue_byte(8'($urandom_range(0, 255)));
            queue_byte(ccfd_pkg::DELIMITER);
        end
        else if (kind < 20)
        begin
            fill_body($urandom_range(0, 3), 4);
            send_body(1'b0, 1'b0, 1'b0);
        end
        else if (kind < 30)
        begin
            fill_body($urandom_range(0, 14), 6);
            send_body(1'b1, 1'b1, 1'b0);
        end
        else
        begin
            if ($urandom_range(0, 14) == 0)
                fill_body($urandom_range(240, 320), 200);
            else
                fill_body($urandom_range(0, 14), 6);
            send_body(1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic set_frame_limit(input logic [15:0] limit);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        dec_limit = limit;
        limit_writes++;
    endtask

    task automatic wait_quiet();
        int spent;
        spent = 0;
        while ((rx_stream.size() != 0 || rx_link.valid || frame_results_due.size() != 0)
               && spent < QUIET_LIMIT)
        begin
            @(negedge clk);
            spent++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [15:0] limit, input int budget, input bit squeeze);
        int start;
        set_frame_limit(limit);
        start = items_queued;
        while (items_queued - start < budget)
            random_frame();
        // Leave a frame open so that the next limit lands in the middle of it.
        if ($urandom_range(0, 1) == 1)
        begin
            fill_body($urandom_range(1, 14), 6);
            send_body(1'b1, 1'b0, 1'b1);
        end
        if (squeeze)
            hold_req = 1'b1;
        wait_quiet();
    endtask

    task automatic check_result();
        decoder_result_t want;
        if (frame_results_due.size() == 0)
        begin
            $error("unexpected result: out_byte %0h out_index %0d frame_end %0b error_code %0d",
                   res_link.out_byte, res_link.out_index, res_link.frame_end,
                   res_link.error_code);
            mismatches++;
        end
        else
        begin
            want = frame_results_due.pop_front();
            if (res_link.out_byte !== want.data)
            begin
                $error("out_byte: expected %0h, actual %0h", want.data, res_link.out_byte);
                mismatches++;
            end
            if (res_link.out_index !== want.index)
            begin
                $error("out_index: expected %0d, actual %0d", want.index, res_link.out_index);
                mismatches++;
            end
            if (res_link.byte_valid !== want.byte_valid)
            begin
                $error("byte_valid: expected %0b, actual %0b", want.byte_valid,
                       res_link.byte_valid);
                mismatches++;
            end
            if (res_link.frame_end !== want.frame_end)
            begin
                $error("frame_end: expected %0b, actual %0b", want.frame_end, res_link.frame_end);
                mismatches++;
            end
            if (res_link.frame_good !== want.frame_good)
            begin
                $error("frame_good: expected %0b, actual %0b", want.frame_good,
                       res_link.frame_good);
                mismatches++;
            end
            if (res_link.frame_len !== want.len)
            begin
                $error("frame_len: expected %0d, actual %0d", want.len, res_link.frame_len);
                mismatches++;
            end
            if (res_link.error_code !== want.err)
            begin
                $error("error_code: expected %0d, actual %0d", want.err, res_link.error_code);
                mismatches++;
            end
        end
        if (res_link.byte_valid === 1'b1)
            bytes_checked++;
        if (res_link.frame_end === 1'b1)
        begin
            frames_checked++;
            if (res_link.frame_good === 1'b1)
                frames_good++;
        end
    endtask

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_link.valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (rx_link.valid && rx_link.ready)
            begin
                cobs_decode_step(rx_link.rx_byte);
                bytes_received++;
            end
            if (rx_link.valid && !rx_link.ready)
            begin
            end
            else if (send_wait > 0)
            begin
                send_wait--;
                rx_link.valid <= 1'b0;
            end
            else if (rx_stream.size() != 0)
            begin
                rx_link.valid <= 1'b1;
                rx_link.rx_byte <= rx_stream.pop_front();
                if ($urandom_range(0, 31) == 0)
                    send_steady = !send_steady;
                send_wait = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else
                rx_link.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_link.ready <= 1'b0;
            take_wait = 0;
        end
        else
        begin
            if (res_link.valid && res_link.ready)
            begin
                check_result();
                if ($urandom_range(0, 31) == 0)
                    take_steady = !take_steady;
                take_wait = take_steady ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold_out)
                res_link.ready <= 1'b0;
            else if (take_wait > 0)
            begin
                take_wait--;
                res_link.ready <= 1'b0;
            end
            else
                res_link.ready <= 1'b1;
        end
    end

    initial
    begin
        hold_out = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("cobs_crc16_frame_decoder_core: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rx_link.valid = 1'b0;
        rx_link.rx_byte = '0;
        res_link.ready = 1'b0;
        hold_req = 1'b0;
        send_steady = 1'b0;
        take_steady = 1'b0;
        items_queued = 0;
        bytes_received = 0;
        bytes_checked = 0;
        frames_checked = 0;
        frames_good = 0;
        limit_writes = 0;
        mismatches = 0;
        dec_limit = ccfd_pkg::MAX_LEN_RESET;
        clear_decoder();

        for (int k = OPENING_LEN - 1; k >= 0; k--)
            queue_byte(OPENING[8*k +: 8]);
        frame_body.push_back(8'h00);
        frame_body.push_back(8'h80);
        send_body(1'b1, 1'b0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_quiet();

        set_frame_limit(16'd2);
        for (int k = SPILL_LEN - 1; k >= 0; k--)
            queue_byte(SPILL[8*k +: 8]);
        wait_quiet();

        run_phase(ccfd_pkg::MAX_LEN_RESET, 250, 1'b1);
        run_phase(16'hFFFF, 250, 1'b0);
        run_phase(16'd3, 100, 1'b0);
        run_phase(16'd0, 40, 1'b0);
        run_phase(16'd1, 60, 1'b0);
        run_phase(16'd40, 160, 1'b0);
        run_phase(16'd300, 200, 1'b0);
        run_phase(16'($urandom_range(4, 600)), 160, 1'b0);

        if (rx_stream.size() != 0)
        begin
            $error("%0d input bytes were never taken", rx_stream.size());
            mismatches += rx_stream.size();
        end
        if (frame_results_due.size() != 0)
        begin
            $error("%0d expected results never arrived", frame_results_due.size());
            mismatches += frame_results_due.size();
        end

        $display("Run covered %0d received bytes under %0d frame length limits, 0 to 65535.",
                 bytes_received, limit_writes);
        $display("Checked %0d decoded bytes and %0d frame reports, %0d of them good frames.",
                 bytes_checked, frames_checked, frames_good);
        if (mismatches == 0)
            $display("cobs_crc16_frame_decoder_core: match");
        else
            $display("cobs_crc16_frame_decoder_core: mismatch");
        $finish;
    end

endmodule
